### src/lbh_pkg.sv
// Shared constants, types and a helper function for the latency bucket histogram.
// Used by the top level latency_bucket_histogram; depends on nothing else.
package lbh_pkg;

    // Counter width of the histogram. Counts are kept no wider than the
    // 32-bit report fields, so they stop at the largest value both can hold.
    localparam int COUNT_WIDTH = 32;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = (COUNT_WIDTH < DATA_W) ? COUNT_WIDTH : DATA_W;

    localparam int NUM_THRESH  = 4;
    localparam int NUM_BUCKETS = NUM_THRESH + 1;
    localparam int BKT_AW      = $clog2(NUM_BUCKETS);
    localparam int CFG_IDX_W   = $clog2(NUM_THRESH);

    localparam logic [BKT_AW-1:0] FIRST_BKT = '0;
    localparam logic [BKT_AW-1:0] LAST_BKT  = BKT_AW'(NUM_BUCKETS - 1);

    // Threshold register values after reset, in register index order.
    localparam logic [DATA_W-1:0] THRESH_RESET [NUM_THRESH] = '{
        32'd20, 32'd100, 32'd1000, 32'd10000
    };

    // Item kinds on the input channel.
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    typedef enum logic [1:0] {
        ST_RUN   = 2'b01,
        ST_SWEEP = 2'b10
    } lbh_state_t;

    // Saturating increment of a count.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + CNT_W'(1);
    endfunction

endpackage

### src/lbh_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Self-contained; no package dependency.
module lbh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the contents before a write in the same cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/latency_bucket_histogram.sv
// Latency bucket histogram: samples are taken one per cycle, back to back, while input is not
// stalled; a tick stalls input while the five bucket counts are swept out of the RAM, until
// its report word has moved to the output register, which it does once that register is free.
// Reset (rst_n low, asynchronous) loads the default thresholds and clears all counts,
// the maximum and the interval number; bucket RAM contents are masked by valid bits.
// Depends on lbh_pkg and lbh_ram.
module latency_bucket_histogram (
    input  logic                         clk,
    input  logic                         rst_n,

    // Configuration write port
    input  logic                         cfg_we,
    input  logic [lbh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lbh_pkg::DATA_W-1:0]   cfg_data,

    // Input channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         kind,
    input  logic [lbh_pkg::DATA_W-1:0]   latency_us,

    // Output channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [lbh_pkg::DATA_W-1:0]   interval_number,
    output logic [lbh_pkg::DATA_W-1:0]   op_count,
    output logic [lbh_pkg::DATA_W-1:0]   bucket_0_count,
    output logic [lbh_pkg::DATA_W-1:0]   bucket_1_count,
    output logic [lbh_pkg::DATA_W-1:0]   bucket_2_count,
    output logic [lbh_pkg::DATA_W-1:0]   bucket_3_count,
    output logic [lbh_pkg::DATA_W-1:0]   bucket_4_count,
    output logic [lbh_pkg::DATA_W-1:0]   max_latency
);

    import lbh_pkg::*;

    // ------------------------------------------------------------------
    // Overview
    //
    // The five bucket counters live in a small RAM with a registered read.
    // A sample word is classified against the thresholds in the cycle it
    // is accepted and its bucket is read; in the next cycle the count is
    // incremented and written back. Because the RAM returns old data when
    // the same entry was written at the same edge as the read, the last
    // write is held in a forwarding register and replaces the RAM data on
    // an address match.
    //
    // A tick word snapshots the sample count, the maximum and the new
    // interval number into a report buffer and then sweeps the five RAM
    // entries through the same read stage. When the last entry has been
    // captured, all bucket valid bits clear at once, which empties the
    // histogram for the next interval without a write sweep. The finished
    // report moves to the output register as soon as that register is free,
    // so samples flow again while the report waits to be taken.
    // ------------------------------------------------------------------

    // Threshold registers
    logic [DATA_W-1:0] thresh_reg [NUM_THRESH];

    // Sequencer
    lbh_state_t        state_reg, state_next;
    logic [BKT_AW-1:0] sweep_idx_reg, sweep_idx_next;

    // Interval state kept in flops
    logic [CNT_W-1:0]  op_cnt_reg, op_cnt_next;
    logic [DATA_W-1:0] max_reg, max_next;
    logic [DATA_W-1:0] intv_reg, intv_next;

    // Read stage: one RAM access in flight
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_rpt_reg, s1_rpt_next;
    logic [BKT_AW-1:0] s1_addr_reg, s1_addr_next;

    // Write forwarding
    logic              fwd_valid_reg, fwd_valid_next;
    logic [BKT_AW-1:0] fwd_addr_reg;
    logic [CNT_W-1:0]  fwd_data_reg;

    // Per-entry valid bits of the bucket RAM
    logic [NUM_BUCKETS-1:0] bkt_valid_reg, bkt_valid_next;

    // Report buffer
    logic              rep_full_reg, rep_full_next;
    logic              rep_done_reg, rep_done_next;
    logic [DATA_W-1:0] rep_intv_reg;
    logic [CNT_W-1:0]  rep_op_reg;
    logic [DATA_W-1:0] rep_max_reg;
    logic [CNT_W-1:0]  rep_bkt_reg [NUM_BUCKETS];

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_intv_reg;
    logic [CNT_W-1:0]  out_op_reg;
    logic [DATA_W-1:0] out_max_reg;
    logic [CNT_W-1:0]  out_bkt_reg [NUM_BUCKETS];

    // Datapath signals
    logic              in_acc;
    logic              is_tick;
    logic [BKT_AW-1:0] bkt_sel;
    logic [BKT_AW-1:0] ram_raddr;
    logic [CNT_W-1:0]  ram_rdata;
    logic [CNT_W-1:0]  cur_count;
    logic              wr_en;
    logic [CNT_W-1:0]  wr_data;
    logic              last_cap;
    logic              xfer;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------

    // Input is held off during the sweep and until the report buffer has
    // handed its report to the output register.
    assign in_stall = (state_reg != ST_RUN) || rep_full_reg;
    assign in_acc   = in_valid && !in_stall;
    assign is_tick  = (kind == KIND_TICK);

    assign xfer = rep_done_reg && (!out_valid_reg || !out_stall);

    // ------------------------------------------------------------------
    // Bucket choice: the first threshold the latency is below wins.
    // ------------------------------------------------------------------
    always_comb
    begin
        bkt_sel = LAST_BKT;
        for (int k = NUM_THRESH - 1; k >= 0; k--)
        begin
            if (latency_us < thresh_reg[k])
            begin
                bkt_sel = BKT_AW'(k);
            end
        end
    end

    // A tick reads the first entry in its own accept cycle; the sweep
    // then reads the rest, one per cycle.
    always_comb
    begin
        if (state_reg == ST_SWEEP)
        begin
            ram_raddr = sweep_idx_reg;
        end
        else if (is_tick)
        begin
            ram_raddr = FIRST_BKT;
        end
        else
        begin
            ram_raddr = bkt_sel;
        end
    end

    // ------------------------------------------------------------------
    // Bucket RAM
    // ------------------------------------------------------------------
    lbh_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_BUCKETS)
    ) u_bkt_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_addr_reg),
        .wdata (wr_data),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Current count of the entry in the read stage: the write of the last
    // cycle if it hit the same entry, else the RAM data if the entry has
    // been written this interval, else zero.
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg))
        begin
            cur_count = fwd_data_reg;
        end
        else if (bkt_valid_reg[s1_addr_reg])
        begin
            cur_count = ram_rdata;
        end
        else
        begin
            cur_count = '0;
        end
    end

    assign wr_en    = s1_valid_reg && !s1_rpt_reg;
    assign wr_data  = sat_inc(cur_count);
    assign last_cap = s1_valid_reg && s1_rpt_reg && (s1_addr_reg == LAST_BKT);

    // ------------------------------------------------------------------
    // Control next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        sweep_idx_next = sweep_idx_reg;
        op_cnt_next    = op_cnt_reg;
        max_next       = max_reg;
        intv_next      = intv_reg;
        rep_full_next  = rep_full_reg;
        rep_done_next  = rep_done_reg;
        out_valid_next = out_valid_reg;
        bkt_valid_next = bkt_valid_reg;

        s1_valid_next = in_acc || (state_reg == ST_SWEEP);
        s1_rpt_next   = (state_reg == ST_SWEEP) || is_tick;
        s1_addr_next  = ram_raddr;

        fwd_valid_next = wr_en;

        unique case (state_reg)
            ST_RUN:
            begin
                if (in_acc && is_tick)
                begin
                    state_next     = ST_SWEEP;
                    sweep_idx_next = FIRST_BKT + BKT_AW'(1);
                end
            end
            ST_SWEEP:
            begin
                if (sweep_idx_reg == LAST_BKT)
                begin
                    state_next = ST_RUN;
                end
                else
                begin
                    sweep_idx_next = sweep_idx_reg + BKT_AW'(1);
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase

        if (in_acc)
        begin
            if (is_tick)
            begin
                intv_next     = intv_reg + DATA_W'(1);
                op_cnt_next   = '0;
                max_next      = '0;
                rep_full_next = 1'b1;
            end
            else
            begin
                op_cnt_next = sat_inc(op_cnt_reg);
                if (latency_us > max_reg)
                begin
                    max_next = latency_us;
                end
            end
        end

        if (wr_en)
        begin
            bkt_valid_next[s1_addr_reg] = 1'b1;
        end

        // The last bucket has been read out: the interval is closed.
        if (last_cap)
        begin
            bkt_valid_next = '0;
            fwd_valid_next = 1'b0;
            rep_done_next  = 1'b1;
        end

        if (xfer)
        begin
            rep_full_next  = 1'b0;
            rep_done_next  = 1'b0;
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_THRESH; k++)
            begin
                thresh_reg[k] <= THRESH_RESET[k];
            end
            state_reg     <= ST_RUN;
            sweep_idx_reg <= FIRST_BKT;
            op_cnt_reg    <= '0;
            max_reg       <= '0;
            intv_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            s1_rpt_reg    <= 1'b0;
            fwd_valid_reg <= 1'b0;
            bkt_valid_reg <= '0;
            rep_full_reg  <= 1'b0;
            rep_done_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                thresh_reg[cfg_index] <= cfg_data;
            end
            state_reg     <= state_next;
            sweep_idx_reg <= sweep_idx_next;
            op_cnt_reg    <= op_cnt_next;
            max_reg       <= max_next;
            intv_reg      <= intv_next;
            s1_valid_reg  <= s1_valid_next;
            s1_rpt_reg    <= s1_rpt_next;
            fwd_valid_reg <= fwd_valid_next;
            bkt_valid_reg <= bkt_valid_next;
            rep_full_reg  <= rep_full_next;
            rep_done_reg  <= rep_done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        s1_addr_reg  <= s1_addr_next;
        fwd_addr_reg <= s1_addr_reg;
        fwd_data_reg <= wr_data;

        if (in_acc && is_tick)
        begin
            rep_intv_reg <= intv_next;
            rep_op_reg   <= op_cnt_reg;
            rep_max_reg  <= max_reg;
        end

        if (s1_valid_reg && s1_rpt_reg)
        begin
            rep_bkt_reg[s1_addr_reg] <= cur_count;
        end

        if (xfer)
        begin
            out_intv_reg <= rep_intv_reg;
            out_op_reg   <= rep_op_reg;
            out_max_reg  <= rep_max_reg;
            for (int k = 0; k < NUM_BUCKETS; k++)
            begin
                out_bkt_reg[k] <= rep_bkt_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign out_valid       = out_valid_reg;
    assign interval_number = out_intv_reg;
    assign op_count        = DATA_W'(out_op_reg);
    assign bucket_0_count  = DATA_W'(out_bkt_reg[0]);
    assign bucket_1_count  = DATA_W'(out_bkt_reg[1]);
    assign bucket_2_count  = DATA_W'(out_bkt_reg[2]);
    assign bucket_3_count  = DATA_W'(out_bkt_reg[3]);
    assign bucket_4_count  = DATA_W'(out_bkt_reg[4]);
    assign max_latency     = out_max_reg;

`ifndef NO_ASSERTIONS
    // No sample write-back may be pending while the buckets are swept out.
    a_no_write_in_sweep: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> !(s1_valid_reg && !s1_rpt_reg)
    ) else $error("sample write-back overlaps the report sweep");

    // Capturing the last bucket closes the interval: every entry reads as zero.
    a_clear_after_sweep: assert property (
        @(posedge clk) disable iff (!rst_n)
        last_cap |=> (bkt_valid_reg == '0) && !fwd_valid_reg
    ) else $error("bucket entries still valid after the report sweep");

    // A new report appears only from a completed sweep.
    a_report_from_sweep: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(rep_done_reg)
    ) else $error("report word issued before its sweep finished");
`endif

endmodule

### tb/latency_bucket_histogram_tb.sv
// Self-checking testbench for latency_bucket_histogram: a directed table of words, then
// random words under several threshold settings and idling patterns, checked by a predictor.
// Depends on lbh_pkg and the latency_bucket_histogram RTL; reads no files.
module latency_bucket_histogram_tb;
    import lbh_pkg::*;

    // Layout of one report word as the checker sees it.
    localparam int REPORT_FIELDS = 8;
    localparam int F_INTERVAL    = 0;
    localparam int F_OPS         = 1;
    localparam int F_BIN0        = 2;
    localparam int F_PEAK        = 7;

    localparam int WORDS_PER_PHASE = 150;
    localparam int NUM_PHASES      = 6;
    // Idle time after each phase, so that the block settles before the next phase.
    localparam int SETTLE_CYCLES   = 12;
    localparam int HOLD_OFF_CYCLES = 300;
    // Longest correct stretch without a handshake is the hold-off plus one sweep.
    localparam int STALL_LIMIT     = 2000;

    localparam logic [DATA_W-1:0] COUNT_CAP = DATA_W'((64'd1 << CNT_W) - 64'd1);

    typedef logic [REPORT_FIELDS-1:0][DATA_W-1:0] report_t;

    typedef struct packed {
        logic                kind;
        logic [DATA_W-1:0]   lat;
        logic                typed;
        report_t             want;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [DATA_W-1:0]     cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  kind;
    logic [DATA_W-1:0]     latency_us;
    logic                  out_valid;
    logic                  out_stall;
    logic [DATA_W-1:0]     interval_number;
    logic [DATA_W-1:0]     op_count;
    logic [DATA_W-1:0]     bucket_0_count;
    logic [DATA_W-1:0]     bucket_1_count;
    logic [DATA_W-1:0]     bucket_2_count;
    logic [DATA_W-1:0]     bucket_3_count;
    logic [DATA_W-1:0]     bucket_4_count;
    logic [DATA_W-1:0]     max_latency;

    // Predicted histogram state: thresholds as last written, the open interval's
    // counts and peak, and how many intervals have been closed so far.
    logic [DATA_W-1:0]     thresh_now [NUM_THRESH];
    logic [DATA_W-1:0]     ops_now;
    logic [DATA_W-1:0]     bins_now [NUM_BUCKETS];
    logic [DATA_W-1:0]     peak_now;
    logic [DATA_W-1:0]     intervals_closed;

    // Reports owed by the block, oldest first.
    report_t               reports_due [$];

    int                    errors        = 0;
    int                    quiet_cycles  = 0;
    int                    hold_left     = 0;
    int                    src_idle_pct  = 29;
    int                    sink_idle_pct = 79;

    string field_name [REPORT_FIELDS] = '{
        "interval_number", "op_count", "bucket_0_count", "bucket_1_count",
        "bucket_2_count", "bucket_3_count", "bucket_4_count", "max_latency"
    };

    latency_bucket_histogram i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .latency_us      (latency_us),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .interval_number (interval_number),
        .op_count        (op_count),
        .bucket_0_count  (bucket_0_count),
        .bucket_1_count  (bucket_1_count),
        .bucket_2_count  (bucket_2_count),
        .bucket_3_count  (bucket_3_count),
        .bucket_4_count  (bucket_4_count),
        .max_latency     (max_latency)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic report_t report_of(input logic [DATA_W-1:0] num, ops,
                                          b0, b1, b2, b3, b4, peak);
        report_t r;
        r[F_INTERVAL] = num;
        r[F_OPS]      = ops;
        r[F_BIN0]     = b0;
        r[F_BIN0 + 1] = b1;
        r[F_BIN0 + 2] = b2;
        r[F_BIN0 + 3] = b3;
        r[F_BIN0 + 4] = b4;
        r[F_PEAK]     = peak;
        return r;
    endfunction

    // Offers one word, entered and left at a falling edge. Valid stays high on return
    // so that back-to-back words never drop it. When the word is taken, the predictor
    // files a sample or closes the interval; a typed expectation replaces the predicted
    // report for the directed rows.
    task automatic send_word(input logic k, input logic [DATA_W-1:0] lat,
                             input logic typed, input report_t want);
        int bin;
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        latency_us <= lat;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);

        if (k == KIND_SAMPLE)
        begin
            // The first threshold that the latency is below picks the bucket, so
            // scanning from the top down leaves the lowest match in place.
            bin = NUM_THRESH;
            for (int t = NUM_THRESH - 1; t >= 0; t--)
                if (lat < thresh_now[t])
                    bin = t;
            if (ops_now != COUNT_CAP)
                ops_now++;
            if (bins_now[bin] != COUNT_CAP)
                bins_now[bin]++;
            if (lat > peak_now)
                peak_now = lat;
        end
        else
        begin
            intervals_closed++;
            if (typed)
                reports_due.push_back(want);
            else
                reports_due.push_back(report_of(intervals_closed, ops_now, bins_now[0],
                    bins_now[1], bins_now[2], bins_now[3], bins_now[4], peak_now));
            ops_now  = '0;
            peak_now = '0;
            foreach (bins_now[b])
                bins_now[b] = '0;
        end
        @(negedge clk);
    endtask

    // Receiver side. A pending hold-off keeps the output stalled until it has run out;
    // otherwise the stall is drawn at the current idling rate.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < sink_idle_pct);
        end
    end

    // Checks each report word taken from the block against the oldest one owed.
    always @(posedge clk)
    begin
        report_t got;
        report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = report_of(interval_number, op_count, bucket_0_count, bucket_1_count,
                            bucket_2_count, bucket_3_count, bucket_4_count, max_latency);
            if (reports_due.size() == 0)
            begin
                if (errors < 10)
                    $display("report word with none due: interval_number %h", got[F_INTERVAL]);
                errors++;
            end
            else
            begin
                want = reports_due.pop_front();
                for (int f = 0; f < REPORT_FIELDS; f++)
                    if (got[f] !== want[f])
                    begin
                        if (errors < 10)
                            $display("%s mismatch: expected %h, got %h",
                                     field_name[f], want[f], got[f]);
                        errors++;
                    end
            end
        end
    end

    // Watchdog: ends the run when neither channel has moved a word for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("latency_bucket_histogram_tb failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        stim_row_t          rows [$];
        logic [DATA_W-1:0]  thr [$];
        logic [DATA_W-1:0]  lat;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        kind       = KIND_SAMPLE;
        latency_us = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;

        for (int t = 0; t < NUM_THRESH; t++)
            thresh_now[t] = THRESH_RESET[t];
        ops_now          = '0;
        peak_now         = '0;
        intervals_closed = '0;
        foreach (bins_now[b])
            bins_now[b] = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table at the reset thresholds 20, 100, 1000 and 10000. An empty
        // interval comes first; then both edges of every bucket and the extreme
        // latencies, so each bucket should hold two samples at the next tick.
        rows.push_back(stim_row_t'{KIND_TICK, '0, 1'b1, report_of(1, 0, 0, 0, 0, 0, 0, 0)});
        rows.push_back(stim_row_t'{KIND_SAMPLE, 32'd0, 1'b0, '0});
        rows.push_back(stim_row_t'{KIND_SAMPLE, 32'd19, 1'b0, '0});
        rows.push_back(stim_row_t'{KIND_SAMPLE, 32'd20, 1'b0, '0});
        rows.push_back(stim_row_t'{KIND_SAMPLE, 32'd99, 1'b0, '0});
        rows.push_back(stim_row_t'{KIND_SAMPLE, 32'd100, 1'b0, '0});
        rows.push_back(stim_row_t'{KIND_SAMPLE, 32'd999, 1'b0, '0});
        rows.push_back(stim_row_t'{KIND_SAMPLE, 32'd1000, 1'b0, '0});
        rows.push_back(stim_row_t'{KIND_SAMPLE, 32'd9999, 1'b0, '0});
        rows.push_back(stim_row_t'{KIND_SAMPLE, 32'd10000, 1'b0, '0});
        rows.push_back(stim_row_t'{KIND_SAMPLE, 32'hFFFF_FFFF, 1'b0, '0});
        rows.push_back(stim_row_t'{KIND_TICK, 32'hFFFF_FFFF, 1'b1,
                                   report_of(2, 10, 2, 2, 2, 2, 2, 32'hFFFF_FFFF)});
        // A tick right after a tick shows that the counts and the peak were cleared.
        rows.push_back(stim_row_t'{KIND_TICK, '0, 1'b1, report_of(3, 0, 0, 0, 0, 0, 0, 0)});
        rows.push_back(stim_row_t'{KIND_SAMPLE, 32'hAAAA_AAAA, 1'b0, '0});
        rows.push_back(stim_row_t'{KIND_SAMPLE, 32'h5555_5555, 1'b0, '0});
        rows.push_back(stim_row_t'{KIND_TICK, 32'h5555_5555, 1'b1,
                                   report_of(4, 2, 0, 0, 0, 0, 2, 32'hAAAA_AAAA)});
        rows.push_back(stim_row_t'{KIND_SAMPLE, 32'd7, 1'b0, '0});
        rows.push_back(stim_row_t'{KIND_SAMPLE, 32'd5000, 1'b0, '0});
        rows.push_back(stim_row_t'{KIND_SAMPLE, 32'd7, 1'b0, '0});
        rows.push_back(stim_row_t'{KIND_TICK, '0, 1'b0, '0});
        foreach (rows[i])
            send_word(rows[i].kind, rows[i].lat, rows[i].typed, rows[i].want);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p == 2)
            begin
                src_idle_pct  = 79;
                sink_idle_pct = 29;
            end
            if (p == 4)
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end

            // Every phase after the first starts with a new threshold set, written
            // while the block is idle: all zero, all ones, descending (so the middle
            // buckets starve), ascending, and fully random.
            if (p > 0)
            begin
                thr = {};
                case (p)
                    1: repeat (NUM_THRESH) thr.push_back('0);
                    2: repeat (NUM_THRESH) thr.push_back('1);
                    3:
                    begin
                        repeat (NUM_THRESH) thr.push_back($urandom_range(30000));
                        thr.rsort();
                    end
                    4:
                    begin
                        repeat (NUM_THRESH) thr.push_back($urandom_range(30000));
                        thr.sort();
                    end
                    default: repeat (NUM_THRESH) thr.push_back($urandom);
                endcase
                for (int t = 0; t < NUM_THRESH; t++)
                begin
                    cfg_we        <= 1'b1;
                    cfg_index     <= CFG_IDX_W'(t);
                    cfg_data      <= thr[t];
                    thresh_now[t]  = thr[t];
                    @(negedge clk);
                end
                cfg_we <= 1'b0;
            end

            // Back pressure: the receiver holds off while ticks keep coming, so the
            // output register fills and the block has to stall its input.
            if (p == 4)
            begin
                hold_left = HOLD_OFF_CYCLES;
                repeat (12)
                begin
                    send_word(KIND_SAMPLE, $urandom, 1'b0, '0);
                    send_word(KIND_TICK, $urandom, 1'b0, '0);
                end
            end

            // Random intervals of about a dozen samples each. Latencies are drawn
            // from the full range, from one below to one above a threshold, from the
            // range of the default thresholds, and from randomly shortened values.
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                if ($urandom_range(11) == 0)
                    send_word(KIND_TICK, $urandom, 1'b0, '0);
                else
                begin
                    case ($urandom_range(3))
                        0: lat = $urandom;
                        1: lat = thresh_now[$urandom_range(NUM_THRESH - 1)]
                                 + DATA_W'($urandom_range(2)) - DATA_W'(1);
                        2: lat = $urandom_range(20000);
                        default: lat = $urandom >> $urandom_range(31);
                    endcase
                    send_word(KIND_SAMPLE, lat, 1'b0, '0);
                end
            end

            // Close the phase with a tick, so that the last report marks the block idle.
            send_word(KIND_TICK, $urandom, 1'b0, '0);
            in_valid <= 1'b0;
            while (reports_due.size() != 0)
                @(negedge clk);
            repeat (SETTLE_CYCLES) @(negedge clk);
        end

        errors += reports_due.size();
        if (errors == 0)
            $display("latency_bucket_histogram_tb passed");
        else
            $display("latency_bucket_histogram_tb failed");
        $finish;
    end

endmodule
